FILE: src/sensor_hub_bus_slave_core_defines.svh
// Assertion macros for the sensor hub bus slave
`ifndef SENSOR_HUB_BUS_SLAVE_CORE_DEFINES_SVH
`define SENSOR_HUB_BUS_SLAVE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define SHBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sensor hub bus slave: implication check failed");
// Next-cycle implication, disabled during reset
`define SHBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sensor hub bus slave: next-cycle check failed");
`else
`define SHBS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SHBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/shbs_pkg.sv
package shbs_pkg;

  // Event kinds carried in the input tuser
  typedef enum logic [2:0] {
    FUNC_CONV  = 3'd0,
    FUNC_MODE  = 3'd1,
    FUNC_START = 3'd2,
    FUNC_ODO   = 3'd3,
    FUNC_SNAP  = 3'd4,
    FUNC_BUS   = 3'd5
  } func_t;

  // Converter channels that are kept
  localparam logic [2:0] CH_LEFT  = 3'd0;
  localparam logic [2:0] CH_RIGHT = 3'd1;
  localparam logic [2:0] CH_GYRO  = 3'd2;
  localparam logic [2:0] CH_FRONT = 3'd3;

  // Two-wire status codes (after masking the low three bits)
  localparam logic [7:0] STATUS_MASK     = 8'hF8;
  localparam logic [7:0] ST_READ_REQ     = 8'hA8;
  localparam logic [7:0] ST_DATA_TX_ACK  = 8'hB8;
  localparam logic [7:0] ST_DATA_TX_NACK = 8'hC0;
  localparam logic [7:0] ST_LAST_TX_ACK  = 8'hC8;
  localparam logic [7:0] ST_ADDR_WRITE   = 8'h60;
  localparam logic [7:0] ST_DATA_RX      = 8'h80;
  localparam logic [7:0] ST_STOP_RX      = 8'hA0;

  // Byte selector codes
  localparam logic [7:0] SEL_AUTO      = 8'd0;
  localparam logic [7:0] SEL_FRONT     = 8'd1;
  localparam logic [7:0] SEL_LEFT      = 8'd2;
  localparam logic [7:0] SEL_RIGHT     = 8'd3;
  localparam logic [7:0] SEL_SNAP_HI   = 8'd4;
  localparam logic [7:0] SEL_SNAP_LO   = 8'd5;
  localparam logic [7:0] SEL_GYRO      = 8'd6;
  localparam logic [7:0] SEL_START     = 8'd7;
  localparam logic [7:0] SEL_RESET     = 8'hFF;
  localparam logic [7:0] UNKNOWN_BYTE  = 8'hFF;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 16;

  // One input event
  typedef struct packed {
    logic [2:0] func;
    logic [2:0] channel;
    logic [7:0] sample;
    logic       pulse_still_high;
    logic [7:0] bus_status;
    logic [7:0] bus_byte;
  } shbs_item_t;

  // One result item
  typedef struct packed {
    logic       stop_request;
    logic       ack_enable;
    logic       release_bus;
    logic       tx_loaded;
    logic [7:0] tx_byte;
  } shbs_res_t;

  // Occupancy of the result buffer
  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } shbs_buf_stat_t;

endpackage

FILE: src/shbs_core.sv
module shbs_core
  import shbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  shbs_item_t item,
  output shbs_res_t  res
);

  logic [7:0]  left_range_r;
  logic [7:0]  right_range_r;
  logic [7:0]  front_range_r;
  logic [7:0]  gyro_level_r;
  logic        auto_mode_r;
  logic        start_flag_r;
  logic [15:0] pulse_count_r;
  logic [15:0] count_snapshot_r;
  logic [7:0]  byte_selector_r;

  logic [7:0] status_m;
  logic [7:0] pick;
  func_t      func;

  assign status_m = item.bus_status & STATUS_MASK;
  assign func     = func_t'(item.func);

  // Select the byte the master reads
  always_comb begin
    case (byte_selector_r)
      SEL_AUTO:    pick = {7'd0, auto_mode_r};
      SEL_FRONT:   pick = front_range_r;
      SEL_LEFT:    pick = left_range_r;
      SEL_RIGHT:   pick = right_range_r;
      SEL_SNAP_HI: pick = count_snapshot_r[15:8];
      SEL_SNAP_LO: pick = count_snapshot_r[7:0];
      SEL_GYRO:    pick = gyro_level_r;
      SEL_START:   pick = {7'd0, start_flag_r};
      default:     pick = UNKNOWN_BYTE;
    endcase
  end

  // Build the result from the current state
  always_comb begin
    res = '0;
    if (func == FUNC_BUS) begin
      res.release_bus = 1'b1;
      case (status_m)
        ST_READ_REQ: begin
          res.tx_byte    = pick;
          res.tx_loaded  = 1'b1;
          res.ack_enable = 1'b1;
        end
        ST_DATA_TX_ACK, ST_LAST_TX_ACK: begin
          res.ack_enable = 1'b0;
        end
        ST_DATA_TX_NACK, ST_ADDR_WRITE, ST_STOP_RX, ST_DATA_RX: begin
          res.ack_enable = 1'b1;
        end
        default: begin
          res.ack_enable   = 1'b1;
          res.stop_request = 1'b1;
        end
      endcase
    end
  end

  // Update the hub state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_range_r     <= '0;
      right_range_r    <= '0;
      front_range_r    <= '0;
      gyro_level_r     <= '0;
      auto_mode_r      <= 1'b1;
      start_flag_r     <= 1'b1;
      pulse_count_r    <= '0;
      count_snapshot_r <= '0;
      byte_selector_r  <= SEL_RESET;
    end else if (accept) begin
      case (func)
        FUNC_CONV: begin
          case (item.channel)
            CH_LEFT:  left_range_r  <= item.sample;
            CH_RIGHT: right_range_r <= item.sample;
            CH_GYRO:  gyro_level_r  <= item.sample;
            CH_FRONT: front_range_r <= item.sample;
            default: ;
          endcase
        end
        FUNC_MODE:  auto_mode_r  <= ~auto_mode_r;
        FUNC_START: start_flag_r <= ~start_flag_r;
        FUNC_ODO: begin
          if (item.pulse_still_high) pulse_count_r <= pulse_count_r + 16'd1;
        end
        FUNC_SNAP: count_snapshot_r <= pulse_count_r;
        FUNC_BUS: begin
          if (status_m == ST_DATA_RX) byte_selector_r <= item.bus_byte;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/shbs_skid.sv
module shbs_skid
  import shbs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  shbs_res_t      push_data,
  output logic           push_ready,
  output logic           out_valid,
  output shbs_res_t      out_data,
  input  logic           out_ready,
  output shbs_buf_stat_t stat
);

  logic      out_valid_r;
  logic      skid_valid_r;
  shbs_res_t out_data_r;
  shbs_res_t skid_data_r;

  assign push_ready      = ~skid_valid_r;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.out_valid  = out_valid_r;
  assign stat.skid_valid = skid_valid_r;

  // Control: refill output from skid first, else from the new request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end
    if (push && !skid_valid_r) begin
      skid_data_r <= push_data;
    end
  end

endmodule

FILE: src/sensor_hub_bus_slave_core.sv
// Sensor hub behind a two-wire slave: one event in, one result out.
// A result is registered in the output register, or first in the skid register while out_tready stalls.
// Throughput: one request per cycle while the skid entry is empty; a two-entry output buffer keeps in_tready high
// while a single result waits.
// Reset: synchronous, active low; clears buffers, flags and counters to one/zero,
// selector to 0xFF.
`include "sensor_hub_bus_slave_core_defines.svh"

module sensor_hub_bus_slave_core
  import shbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata fields, low bit up: channel[2:0], sample[10:3], pulse_still_high[11],
  // bus_status[19:12], bus_byte[27:20], zero fill[31:28]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser fields, low bit up: func[2:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata fields, low bit up: tx_byte[7:0], tx_loaded[8], release_bus[9],
  // ack_enable[10], stop_request[11], zero fill[15:12]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  logic           accept;
  shbs_item_t     item;
  shbs_res_t      res;
  shbs_res_t      out_res;
  shbs_buf_stat_t stat;

  // Unpack the incoming request
  assign item.func             = in_tuser[2:0];
  assign item.channel          = in_tdata[2:0];
  assign item.sample           = in_tdata[10:3];
  assign item.pulse_still_high = in_tdata[11];
  assign item.bus_status       = in_tdata[19:12];
  assign item.bus_byte         = in_tdata[27:20];

  assign accept = in_tvalid & in_tready;

  shbs_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .res    (res)
  );

  shbs_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready),
    .stat       (stat)
  );

  // Pack the result
  assign out_tdata = {4'd0, out_res.stop_request, out_res.ack_enable,
                      out_res.release_bus, out_res.tx_loaded, out_res.tx_byte};

  `SHBS_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, stat.skid_valid, stat.out_valid)
  `SHBS_ASSERT_IMPL(a_stop_releases, clk, rst_n, out_tvalid && out_res.stop_request,
                    out_res.release_bus && out_res.ack_enable && !out_res.tx_loaded)
  `SHBS_ASSERT_NEXT(a_accept_fills, clk, rst_n, accept, out_tvalid)

endmodule

FILE: tb/sv/tb_sensor_hub_bus_slave_core.sv
module tb_sensor_hub_bus_slave_core;
  timeunit 1ns;
  timeprecision 1ps;
  import shbs_pkg::*;

  // Event codes outside the package enum, and bus codes outside the known set
  localparam logic [2:0] FUNC_SPARE_6   = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7   = 3'd7;
  localparam logic [7:0] ST_UNKNOWN_LOW = 8'h00;
  localparam logic [7:0] ST_UNKNOWN_TOP = 8'hF8;

  localparam int unsigned RANDOM_PER_PHASE = 300;
  localparam int unsigned HOLD_OFF_CYCLES  = 40;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned MAX_REPORTS      = 10;
  localparam int unsigned ODO_BURST        = 5;

  // Responses that can be read off at a glance
  localparam shbs_res_t RES_IDLE = '0;
  localparam shbs_res_t RES_RELEASE = '{stop_request: 1'b0, ack_enable: 1'b0,
                                        release_bus: 1'b1, tx_loaded: 1'b0, tx_byte: 8'h00};
  localparam shbs_res_t RES_ACK = '{stop_request: 1'b0, ack_enable: 1'b1,
                                    release_bus: 1'b1, tx_loaded: 1'b0, tx_byte: 8'h00};
  localparam shbs_res_t RES_STOP = '{stop_request: 1'b1, ack_enable: 1'b1,
                                     release_bus: 1'b1, tx_loaded: 1'b0, tx_byte: 8'h00};
  localparam shbs_res_t RES_LOAD_FF = '{stop_request: 1'b0, ack_enable: 1'b1,
                                        release_bus: 1'b1, tx_loaded: 1'b1,
                                        tx_byte: UNKNOWN_BYTE};

  typedef enum logic [1:0] {
    IDLE_RX_HEAVY,
    IDLE_TX_HEAVY,
    IDLE_NONE
  } idle_mode_t;

  typedef struct {
    shbs_item_t ev;
    bit         typed;
    shbs_res_t  want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // Shadow state of the hub
  logic [7:0]  hub_left = '0;
  logic [7:0]  hub_right = '0;
  logic [7:0]  hub_front = '0;
  logic [7:0]  hub_gyro = '0;
  logic        hub_auto = 1'b1;
  logic        hub_start = 1'b1;
  logic [15:0] hub_pulses = '0;
  logic [15:0] hub_snapshot = '0;
  logic [7:0]  hub_sel = SEL_RESET;

  shbs_res_t   pending_responses[$];
  step_row_t   script[$];
  idle_mode_t  idle_mode = IDLE_RX_HEAVY;
  bit          hold_off_asked = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  sensor_hub_bus_slave_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one event to the shadow state and return the response it gives
  function automatic shbs_res_t hub_response(input shbs_item_t ev);
    shbs_res_t r;
    r = RES_IDLE;
    case (ev.func)
      FUNC_CONV: begin
        case (ev.channel)
          CH_LEFT:  hub_left = ev.sample;
          CH_RIGHT: hub_right = ev.sample;
          CH_GYRO:  hub_gyro = ev.sample;
          CH_FRONT: hub_front = ev.sample;
          default: ;
        endcase
      end
      FUNC_MODE:  hub_auto = ~hub_auto;
      FUNC_START: hub_start = ~hub_start;
      FUNC_ODO: begin
        if (ev.pulse_still_high) hub_pulses = hub_pulses + 16'd1;
      end
      FUNC_SNAP:  hub_snapshot = hub_pulses;
      FUNC_BUS: begin
        r.release_bus = 1'b1;
        case (ev.bus_status & STATUS_MASK)
          ST_READ_REQ: begin
            r.tx_loaded = 1'b1;
            r.ack_enable = 1'b1;
            case (hub_sel)
              SEL_AUTO:    r.tx_byte = {7'd0, hub_auto};
              SEL_FRONT:   r.tx_byte = hub_front;
              SEL_LEFT:    r.tx_byte = hub_left;
              SEL_RIGHT:   r.tx_byte = hub_right;
              SEL_SNAP_HI: r.tx_byte = hub_snapshot[15:8];
              SEL_SNAP_LO: r.tx_byte = hub_snapshot[7:0];
              SEL_GYRO:    r.tx_byte = hub_gyro;
              SEL_START:   r.tx_byte = {7'd0, hub_start};
              default:     r.tx_byte = UNKNOWN_BYTE;
            endcase
          end
          ST_DATA_TX_ACK, ST_LAST_TX_ACK: ;
          ST_DATA_TX_NACK, ST_ADDR_WRITE, ST_STOP_RX: r.ack_enable = 1'b1;
          ST_DATA_RX: begin
            hub_sel = ev.bus_byte;
            r.ack_enable = 1'b1;
          end
          default: begin
            r.ack_enable = 1'b1;
            r.stop_request = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_row_t step_row(input logic [2:0] func, input logic [2:0] channel,
                                         input logic [7:0] sample, input logic held,
                                         input logic [7:0] status, input logic [7:0] rx,
                                         input bit typed, input shbs_res_t want);
    step_row_t r;
    r.ev = '{func, channel, sample, held, status, rx};
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Mostly well-formed traffic: selector writes and reads, sensor updates, noise
  function automatic shbs_item_t random_event();
    shbs_item_t ev;
    logic [30:0] noise;
    int unsigned pick;
    noise = 31'($urandom);
    ev = noise;
    pick = $urandom_range(99);
    if (pick < 30) begin
      ev.func = FUNC_CONV;
      ev.channel = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
    end else if (pick < 37) begin
      ev.func = FUNC_MODE;
    end else if (pick < 43) begin
      ev.func = FUNC_START;
    end else if (pick < 58) begin
      ev.func = FUNC_ODO;
    end else if (pick < 63) begin
      ev.func = FUNC_SNAP;
    end else if (pick < 96) begin
      ev.func = FUNC_BUS;
      case ($urandom_range(9))
        0, 1: begin
          ev.bus_status = ST_DATA_RX | 8'($urandom_range(7));
          if ($urandom_range(4) != 0) ev.bus_byte = 8'($urandom_range(7));
        end
        2, 3, 4: ev.bus_status = ST_READ_REQ | 8'($urandom_range(7));
        5: ev.bus_status = ($urandom_range(1) == 0) ? ST_DATA_TX_ACK : ST_LAST_TX_ACK;
        6: begin
          case ($urandom_range(2))
            0: ev.bus_status = ST_DATA_TX_NACK;
            1: ev.bus_status = ST_ADDR_WRITE;
            default: ev.bus_status = ST_STOP_RX;
          endcase
          ev.bus_status = ev.bus_status | 8'($urandom_range(7));
        end
        default: ev.bus_status = 8'($urandom_range(255));
      endcase
    end else begin
      ev.func = ($urandom_range(1) == 0) ? FUNC_SPARE_6 : FUNC_SPARE_7;
    end
    return ev;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_RX_HEAVY: return $urandom_range(99) < 9;
      IDLE_TX_HEAVY: return $urandom_range(99) < 68;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RX_HEAVY: return $urandom_range(99) < 68;
      IDLE_TX_HEAVY: return $urandom_range(99) < 9;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // Offer one request, wait for it to be taken, then record its response
  task automatic offer_request(input shbs_item_t ev, input bit typed, input shbs_res_t want);
    shbs_res_t predicted;
    @(negedge clk);
    while (sender_idles()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata <= {4'd0, ev.bus_byte, ev.bus_status, ev.pulse_still_high, ev.sample,
                 ev.channel};
    in_tuser <= ev.func;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = hub_response(ev);
    pending_responses.push_back(typed ? want : predicted);
  endtask

  // Drive the result side, with one long hold-off on request
  initial begin : response_sink
    forever begin
      @(negedge clk);
      if (hold_off_asked) begin
        hold_off_asked = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_tready <= !receiver_stalls();
      end
    end
  end

  // Compare every response taken against the oldest one outstanding
  always @(posedge clk) begin : response_check
    shbs_res_t want;
    shbs_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[11:0];
      if (pending_responses.size() == 0) begin
        note_mismatch("unexpected response", 16'h0000, out_tdata);
      end else begin
        want = pending_responses.pop_front();
        if (got.tx_byte !== want.tx_byte)
          note_mismatch("tx_byte", 16'(want.tx_byte), 16'(got.tx_byte));
        if (got.tx_loaded !== want.tx_loaded)
          note_mismatch("tx_loaded", 16'(want.tx_loaded), 16'(got.tx_loaded));
        if (got.release_bus !== want.release_bus)
          note_mismatch("release_bus", 16'(want.release_bus), 16'(got.release_bus));
        if (got.ack_enable !== want.ack_enable)
          note_mismatch("ack_enable", 16'(want.ack_enable), 16'(got.ack_enable));
        if (got.stop_request !== want.stop_request)
          note_mismatch("stop_request", 16'(want.stop_request), 16'(got.stop_request));
        if (out_tdata[15:12] !== 4'd0)
          note_mismatch("zero fill", 16'h0000, {12'd0, out_tdata[15:12]});
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    shbs_item_t ev;

    // Readback of the reset selector and the auto flag, then updates of each flag and sensor register
    script.push_back(step_row(FUNC_BUS, 3'd7, 8'hFF, 1'b1, ST_READ_REQ, 8'hFF, 1'b1,
                              RES_LOAD_FF));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_DATA_RX, SEL_AUTO, 1'b1,
                              RES_ACK));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_READ_REQ | 8'h07, 8'h00,
                              1'b0, RES_IDLE));
    script.push_back(step_row(FUNC_MODE, 3'd7, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1, RES_IDLE));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_READ_REQ, 8'h00, 1'b0,
                              RES_IDLE));
    script.push_back(step_row(FUNC_START, 3'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1, RES_IDLE));
    script.push_back(step_row(FUNC_CONV, CH_LEFT, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b1,
                              RES_IDLE));
    script.push_back(step_row(FUNC_CONV, CH_RIGHT, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1,
                              RES_IDLE));
    script.push_back(step_row(FUNC_CONV, CH_GYRO, 8'hA5, 1'b0, 8'h00, 8'h00, 1'b1,
                              RES_IDLE));
    script.push_back(step_row(FUNC_CONV, CH_FRONT, 8'h5A, 1'b0, 8'h00, 8'h00, 1'b1,
                              RES_IDLE));
    // Other channel leaves the sensor registers alone
    script.push_back(step_row(FUNC_CONV, 3'd7, 8'h3C, 1'b1, 8'hFF, 8'hFF, 1'b1, RES_IDLE));
    // Held pulse counts, released pulse does not
    script.push_back(step_row(FUNC_ODO, 3'd0, 8'h00, 1'b1, 8'h00, 8'h00, 1'b1, RES_IDLE));
    script.push_back(step_row(FUNC_ODO, 3'd7, 8'hFF, 1'b0, 8'hFF, 8'hFF, 1'b1, RES_IDLE));
    script.push_back(step_row(FUNC_SNAP, 3'd0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b1, RES_IDLE));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_DATA_RX | 8'h07, SEL_SNAP_LO,
                              1'b1, RES_ACK));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_READ_REQ, 8'h00, 1'b0,
                              RES_IDLE));
    // Every other status code, with and without low bits set
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_DATA_TX_ACK, 8'h00, 1'b1,
                              RES_RELEASE));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_LAST_TX_ACK | 8'h07, 8'h00,
                              1'b1, RES_RELEASE));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_DATA_TX_NACK, 8'h00, 1'b1,
                              RES_ACK));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_ADDR_WRITE, 8'h00, 1'b1,
                              RES_ACK));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_STOP_RX | 8'h07, 8'h00, 1'b1,
                              RES_ACK));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_UNKNOWN_LOW, 8'h00, 1'b1,
                              RES_STOP));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_UNKNOWN_TOP, 8'h00, 1'b1,
                              RES_STOP));
    // Unused event codes
    script.push_back(step_row(FUNC_SPARE_6, 3'd7, 8'hFF, 1'b1, ST_DATA_RX, 8'hFF, 1'b1,
                              RES_IDLE));
    script.push_back(step_row(FUNC_SPARE_7, 3'd0, 8'h00, 1'b0, ST_READ_REQ, 8'h00, 1'b1,
                              RES_IDLE));
    // Selector just past the known range reads as all ones
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_DATA_RX, 8'h08, 1'b1,
                              RES_ACK));
    script.push_back(step_row(FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_READ_REQ, 8'h00, 1'b1,
                              RES_LOAD_FF));

    // Hold reset, release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows, then random traffic under each idling mode
    foreach (script[i]) offer_request(script[i].ev, script[i].typed, script[i].want);
    repeat (RANDOM_PER_PHASE) offer_request(random_event(), 1'b0, RES_IDLE);

    idle_mode = IDLE_TX_HEAVY;
    repeat (RANDOM_PER_PHASE) offer_request(random_event(), 1'b0, RES_IDLE);

    // Stall the result side while requests keep coming
    idle_mode = IDLE_NONE;
    hold_off_asked = 1'b1;
    repeat (RANDOM_PER_PHASE) offer_request(random_event(), 1'b0, RES_IDLE);

    // Count a short burst of held pulses, then read both snapshot bytes back
    ev = '{FUNC_ODO, 3'd0, 8'h00, 1'b1, 8'h00, 8'h00};
    repeat (ODO_BURST) offer_request(ev, 1'b0, RES_IDLE);
    ev.func = FUNC_SNAP;
    offer_request(ev, 1'b0, RES_IDLE);
    ev = '{FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_DATA_RX, SEL_SNAP_HI};
    offer_request(ev, 1'b0, RES_IDLE);
    ev.bus_status = ST_READ_REQ;
    offer_request(ev, 1'b0, RES_IDLE);
    ev = '{FUNC_BUS, 3'd0, 8'h00, 1'b0, ST_DATA_RX, SEL_SNAP_LO};
    offer_request(ev, 1'b0, RES_IDLE);
    ev.bus_status = ST_READ_REQ;
    offer_request(ev, 1'b0, RES_IDLE);

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then keep watching for any stray response
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
